// File: rtl/spp_pkg.sv
// ----------------------------------------------------------------------------
// spp_pkg: shared types and constants of the sonar proximity phrase builder
// Token codes, sensor vectors, bucket bounds and the distance bucket function.
// ----------------------------------------------------------------------------
package spp_pkg;

  localparam int SENSORS = 3;
  localparam int RANGE_W = 16;
  localparam int SUM_W   = 20;
  localparam int CODE_W  = 5;

  typedef logic [RANGE_W-1:0] range_t;
  typedef logic [SUM_W-1:0]   sum_t;
  typedef logic [CODE_W-1:0]  code_t;
  typedef logic [1:0]         cfg_idx_t;

  typedef range_t [SENSORS-1:0] range_vec_t;
  typedef sum_t   [SENSORS-1:0] sum_vec_t;

  typedef struct packed {
    code_t code;
    logic  last;
  } token_t;

  // Phrase tokens.
  localparam code_t TOKEN_FRONT  = 5'd0;
  localparam code_t TOKEN_LEFT   = 5'd1;
  localparam code_t TOKEN_RIGHT  = 5'd2;
  localparam code_t TOKEN_FAR    = 5'd4;
  localparam code_t TOKEN_CLOSE  = 5'd6;
  localparam code_t TOKEN_METRE1 = 5'd8;

  // Sensor order is left, front, right.
  localparam code_t SIDE_TOKEN [SENSORS] = '{TOKEN_LEFT, TOKEN_FRONT, TOKEN_RIGHT};

  // Configuration register indexes and reset values.
  localparam cfg_idx_t CFG_SPREAD = 2'd0;
  localparam cfg_idx_t CFG_NEAR   = 2'd1;
  localparam cfg_idx_t CFG_MODE   = 2'd2;
  localparam range_t   SPREAD_RESET = 16'd50;
  localparam range_t   NEAR_RESET   = 16'd80;

  // Distance buckets in centimeters.
  localparam range_t BUCKET_CLOSE_CM = 16'd50;
  localparam range_t BUCKET_FAR_CM   = 16'd1050;
  localparam int     BOUNDS = 9;
  localparam range_t BUCKET_BOUND [BOUNDS] = '{
    16'd150, 16'd250, 16'd350, 16'd450, 16'd550,
    16'd650, 16'd750, 16'd850, 16'd950
  };

  // Each crossed 100 cm bound adds one meter to the spoken distance.
  function automatic code_t bucket_code(range_t d);
    code_t step;
    code_t code;
    step = '0;
    for (int i = 0; i < BOUNDS; i++) begin
      if (d > BUCKET_BOUND[i]) begin
        step = step + 5'd1;
      end
    end
    if (d <= BUCKET_CLOSE_CM) begin
      code = TOKEN_CLOSE;
    end else if (d > BUCKET_FAR_CM) begin
      code = TOKEN_FAR;
    end else begin
      code = TOKEN_METRE1 + step;
    end
    return code;
  endfunction

endpackage

// File: rtl/spp_accum.sv
// ----------------------------------------------------------------------------
// spp_accum: per-sensor sweep accumulator
// Keeps sum, minimum and maximum per sensor and hands off a finished group.
// ----------------------------------------------------------------------------
module spp_accum #(
  parameter int ROUNDS = 3
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  spp_pkg::range_vec_t in_range,
  output logic               grp_valid,
  input  logic               grp_take,
  output spp_pkg::sum_vec_t   grp_sum,
  output spp_pkg::range_vec_t grp_spread
);
  import spp_pkg::*;

  localparam logic [3:0] LAST_SWEEP = 4'(ROUNDS - 1);

  logic [3:0] cnt_r, cnt_nxt;
  sum_vec_t   sum_r, sum_nxt;
  range_vec_t min_r, min_nxt;
  range_vec_t max_r, max_nxt;
  range_vec_t spread_nxt;
  logic       grp_vld_r, grp_vld_nxt;
  sum_vec_t   grp_sum_r;
  range_vec_t grp_spread_r;
  logic       first_sweep, last_sweep, accept;

  assign first_sweep = (cnt_r == 4'd0);
  assign last_sweep  = (cnt_r == LAST_SWEEP);

  // Only the sweep that closes a group needs room downstream.
  assign in_stall = last_sweep && grp_vld_r && !grp_take;
  assign accept   = in_valid && !in_stall;

  always_comb begin
    for (int s = 0; s < SENSORS; s++) begin
      if (first_sweep) begin
        sum_nxt[s] = SUM_W'(in_range[s]);
        min_nxt[s] = in_range[s];
        max_nxt[s] = in_range[s];
      end else begin
        sum_nxt[s] = sum_r[s] + SUM_W'(in_range[s]);
        min_nxt[s] = (in_range[s] < min_r[s]) ? in_range[s] : min_r[s];
        max_nxt[s] = (in_range[s] > max_r[s]) ? in_range[s] : max_r[s];
      end
      spread_nxt[s] = max_nxt[s] - min_nxt[s];
    end
  end

  always_comb begin
    cnt_nxt = cnt_r;
    if (accept) begin
      cnt_nxt = last_sweep ? 4'd0 : cnt_r + 4'd1;
    end
    grp_vld_nxt = grp_vld_r;
    if (accept && last_sweep) begin
      grp_vld_nxt = 1'b1;
    end else if (grp_take) begin
      grp_vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r     <= '0;
      grp_vld_r <= 1'b0;
    end else begin
      cnt_r     <= cnt_nxt;
      grp_vld_r <= grp_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      sum_r <= sum_nxt;
      min_r <= min_nxt;
      max_r <= max_nxt;
    end
    if (accept && last_sweep) begin
      grp_sum_r    <= sum_nxt;
      grp_spread_r <= spread_nxt;
    end
  end

  assign grp_valid  = grp_vld_r;
  assign grp_sum    = grp_sum_r;
  assign grp_spread = grp_spread_r;

endmodule

// File: rtl/spp_dist.sv
// ----------------------------------------------------------------------------
// spp_dist: group distance stage
// Averages each sensor by a reciprocal multiply and applies the spread check.
// ----------------------------------------------------------------------------
module spp_dist #(
  parameter int ROUNDS = 3
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               grp_valid,
  output logic               grp_take,
  input  spp_pkg::sum_vec_t   grp_sum,
  input  spp_pkg::range_vec_t grp_spread,
  input  spp_pkg::range_t     spread_limit,
  output logic               d_valid,
  input  logic               d_take,
  output spp_pkg::range_vec_t d_dist
);
  import spp_pkg::*;

  // Rounded-up reciprocal; exact for every sum below 2**SUM_W.
  localparam int DIV_SHIFT = SUM_W + $clog2(ROUNDS);
  localparam int MUL_W     = DIV_SHIFT + 1;
  localparam int PROD_W    = SUM_W + MUL_W;
  localparam logic [MUL_W-1:0] DIV_MUL =
    MUL_W'(((64'd1 << DIV_SHIFT) + 64'(ROUNDS) - 64'd1) / 64'(ROUNDS));

  logic [PROD_W-1:0] prod [SENSORS];
  range_vec_t        dist_nxt;
  range_vec_t        dist_r;
  logic              d_vld_r, d_vld_nxt;

  always_comb begin
    for (int s = 0; s < SENSORS; s++) begin
      prod[s] = PROD_W'(grp_sum[s]) * PROD_W'(DIV_MUL);
      if (grp_spread[s] > spread_limit) begin
        dist_nxt[s] = '0;
      end else begin
        dist_nxt[s] = prod[s][DIV_SHIFT +: RANGE_W];
      end
    end
  end

  assign grp_take = grp_valid && (!d_vld_r || d_take);

  always_comb begin
    d_vld_nxt = d_vld_r;
    if (grp_take) begin
      d_vld_nxt = 1'b1;
    end else if (d_take) begin
      d_vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      d_vld_r <= 1'b0;
    end else begin
      d_vld_r <= d_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (grp_take) begin
      dist_r <= dist_nxt;
    end
  end

  assign d_valid = d_vld_r;
  assign d_dist  = dist_r;

endmodule

// File: rtl/spp_phrase.sv
// ----------------------------------------------------------------------------
// spp_phrase: phrase builder and token serializer
// Turns three distances into a token list and sends one token per item.
// ----------------------------------------------------------------------------
module spp_phrase (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               d_valid,
  output logic               d_take,
  input  spp_pkg::range_vec_t d_dist,
  input  spp_pkg::range_t     near_limit,
  input  logic               panorama_mode,
  output logic               out_valid,
  input  logic               out_stall,
  output spp_pkg::code_t      out_track_code,
  output logic               out_last_token
);
  import spp_pkg::*;

  localparam int MAX_TOK = 2 * SENSORS;

  token_t     tok_r   [MAX_TOK];
  token_t     tok_nxt [MAX_TOK];
  logic [2:0] cnt_nxt;
  logic [2:0] ph_cnt_r;
  logic [2:0] ph_idx_r;
  logic       ph_vld_r;
  logic       final_tok, out_acc, ph_free;

  always_comb begin
    for (int k = 0; k < MAX_TOK; k++) begin
      tok_nxt[k] = '0;
    end
    cnt_nxt = '0;
    if (panorama_mode) begin
      for (int s = 0; s < SENSORS; s++) begin
        tok_nxt[2*s]   = '{code: SIDE_TOKEN[s], last: 1'b0};
        tok_nxt[2*s+1] = '{code: bucket_code(d_dist[s]), last: (s == SENSORS - 1)};
      end
      cnt_nxt = 3'(MAX_TOK);
    end else begin
      // Near sensors are compacted to the front of the list, in sensor order.
      for (int s = 0; s < SENSORS; s++) begin
        if (d_dist[s] < near_limit) begin
          tok_nxt[cnt_nxt] = '{code: SIDE_TOKEN[s], last: 1'b0};
          cnt_nxt = cnt_nxt + 3'd1;
        end
      end
      if (cnt_nxt != 3'd0) begin
        tok_nxt[cnt_nxt] = '{code: TOKEN_CLOSE, last: 1'b1};
        cnt_nxt = cnt_nxt + 3'd1;
      end
    end
  end

  assign final_tok = (ph_idx_r == ph_cnt_r - 3'd1);
  assign out_acc   = ph_vld_r && !out_stall;
  assign ph_free   = !ph_vld_r || (out_acc && final_tok);
  assign d_take    = d_valid && ph_free;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ph_vld_r <= 1'b0;
      ph_idx_r <= '0;
      ph_cnt_r <= '0;
    end else if (d_take) begin
      ph_vld_r <= (cnt_nxt != 3'd0);
      ph_idx_r <= '0;
      ph_cnt_r <= cnt_nxt;
    end else if (out_acc) begin
      if (final_tok) begin
        ph_vld_r <= 1'b0;
      end else begin
        ph_idx_r <= ph_idx_r + 3'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (d_take) begin
      tok_r <= tok_nxt;
    end
  end

  assign out_valid      = ph_vld_r;
  assign out_track_code = tok_r[ph_idx_r].code;
  assign out_last_token = tok_r[ph_idx_r].last;

endmodule

// File: rtl/sonar_proximity_phrase_builder.sv
// ----------------------------------------------------------------------------
// sonar_proximity_phrase_builder: top level
// Groups sonar sweeps, averages them and speaks a proximity phrase as tokens.
// ----------------------------------------------------------------------------
// Path: after the sweep that closes a group is accepted, the first token of its
// phrase passes the accumulate, average and phrase registers. Throughput: one
// sweep per cycle; a group yields up to six tokens, sent one per cycle unless
// stalled, so the input stalls only on a closing sweep while a phrase drains.
// Reset: synchronous, active low; clears all pipeline valids and the sweep
// count, and loads the register defaults (spread 50, near 80, continuous mode).
module sonar_proximity_phrase_builder #(
  parameter int ROUNDS = 3
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  spp_pkg::range_t    in_left_range,
  input  spp_pkg::range_t    in_front_range,
  input  spp_pkg::range_t    in_right_range,
  output logic              out_valid,
  input  logic              out_stall,
  output spp_pkg::code_t     out_track_code,
  output logic              out_last_token,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  spp_pkg::cfg_idx_t  cfg_index,
  input  spp_pkg::range_t    cfg_data
);
  import spp_pkg::*;

  // Configuration registers. Writes are always taken; an index past the
  // register list is dropped.
  range_t spread_limit_r;
  range_t near_limit_r;
  logic   panorama_mode_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      spread_limit_r  <= SPREAD_RESET;
      near_limit_r    <= NEAR_RESET;
      panorama_mode_r <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_SPREAD: spread_limit_r  <= cfg_data;
        CFG_NEAR:   near_limit_r    <= cfg_data;
        CFG_MODE:   panorama_mode_r <= cfg_data[0];
        default: begin
        end
      endcase
    end
  end

  // Sensor vector: index 0 is left, 1 is front, 2 is right.
  range_vec_t in_range;
  assign in_range[0] = in_left_range;
  assign in_range[1] = in_front_range;
  assign in_range[2] = in_right_range;

  logic       grp_valid, grp_take;
  sum_vec_t   grp_sum;
  range_vec_t grp_spread;
  logic       d_valid, d_take;
  range_vec_t d_dist;

  // Stage one: running sums and extremes; a closing sweep snapshots the group.
  spp_accum #(
    .ROUNDS(ROUNDS)
  ) u_accum (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_range   (in_range),
    .grp_valid  (grp_valid),
    .grp_take   (grp_take),
    .grp_sum    (grp_sum),
    .grp_spread (grp_spread)
  );

  // Stage two: average by reciprocal multiply, zero on excessive spread.
  spp_dist #(
    .ROUNDS(ROUNDS)
  ) u_dist (
    .clk          (clk),
    .rst_n        (rst_n),
    .grp_valid    (grp_valid),
    .grp_take     (grp_take),
    .grp_sum      (grp_sum),
    .grp_spread   (grp_spread),
    .spread_limit (spread_limit_r),
    .d_valid      (d_valid),
    .d_take       (d_take),
    .d_dist       (d_dist)
  );

  // Stage three: build the token list and send it out one item at a time.
  // A group with nothing to say leaves no phrase behind.
  spp_phrase u_phrase (
    .clk            (clk),
    .rst_n          (rst_n),
    .d_valid        (d_valid),
    .d_take         (d_take),
    .d_dist         (d_dist),
    .near_limit     (near_limit_r),
    .panorama_mode  (panorama_mode_r),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_track_code (out_track_code),
    .out_last_token (out_last_token)
  );

endmodule

// File: rtl/spp_checker.sv
// ----------------------------------------------------------------------------
// spp_checker: port-level checks for the sonar proximity phrase builder
// Watches the result channel over time; bound to the top level below.
// ----------------------------------------------------------------------------
module spp_checker (
  input logic           clk,
  input logic           rst_n,
  input logic           out_valid,
  input logic           out_stall,
  input spp_pkg::code_t out_track_code,
  input logic           out_last_token
);
  import spp_pkg::*;

  // Nothing is offered in the cycle after reset.
  a_reset_quiet: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result offered right after reset");

  // A stalled token holds.
  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_track_code)
                               && $stable(out_last_token))
    else $error("stalled token changed");

  // A phrase is sent without gaps until its last token.
  a_no_gap: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_stall && !out_last_token |=> out_valid)
    else $error("gap inside a phrase");

  // A phrase never ends on a sensor location token.
  a_last_kind: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_last_token |-> out_track_code != TOKEN_LEFT
      && out_track_code != TOKEN_FRONT && out_track_code != TOKEN_RIGHT)
    else $error("phrase ends on a location token");

endmodule

bind sonar_proximity_phrase_builder spp_checker u_spp_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .out_valid      (out_valid),
  .out_stall      (out_stall),
  .out_track_code (out_track_code),
  .out_last_token (out_last_token)
);

// File: dv/tb_sonar_proximity_phrase_builder.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_sonar_proximity_phrase_builder: self-checking testbench
// Feeds sonar sweeps and register writes into the phrase builder and checks
// every spoken token against an in-bench model of grouping, averaging, spread
// rejection and phrase building. A directed plan comes first, then random
// sweep groups under three idle patterns on the input and output channels.
// ----------------------------------------------------------------------------
module tb_sonar_proximity_phrase_builder;
  import spp_pkg::*;

  localparam int ROUNDS = 3;
  // Idle wait after the owed tokens drain; it lets a sweep still in the
  // accumulate stage land before a register write.
  localparam int SETTLE_CYCLES = 10;
  // The limit leaves room for the slowest correct run: about 43 groups of six
  // tokens, each token waiting out a long receiver stall, plus sender gaps.
  localparam int CYCLE_LIMIT = 200000;
  localparam int PHASES = 6;
  localparam int PHASE_SWEEPS = 17;
  localparam int PLAN_ROWS = 32;

  // Index 3 is not a register; writes to it must leave every setting alone.
  localparam cfg_idx_t CFG_UNUSED = 2'd3;
  localparam range_t RMAX = 16'hFFFF;
  localparam range_t METRE_CM = 16'd100;
  localparam code_t TOKEN_TEN_M = TOKEN_METRE1 + 5'd9;

  // Up to six tokens, the first one in the leftmost slot.
  typedef code_t [5:0] phrase_t;
  localparam phrase_t NO_PHRASE = '0;

  // A sweep row is checked by the model, a typed row carries its own answer,
  // and a register row writes data field a to register idx. The idx field is
  // ignored on sweep rows.
  typedef enum logic [1:0] {ROW_SWEEP, ROW_TYPED, ROW_REG} row_kind_e;
  typedef struct packed {
    row_kind_e  kind;
    cfg_idx_t   idx;
    range_t     a;
    range_t     b;
    range_t     c;
    logic [2:0] n_due;
    phrase_t    due;
  } plan_row_t;

  localparam plan_row_t PLAN [PLAN_ROWS] = '{
    // Reset settings, continuous mode: a group of zeros is near on all sides.
    '{ROW_SWEEP, CFG_SPREAD, 16'd0, 16'd0, 16'd0, 3'd0, NO_PHRASE},
    '{ROW_SWEEP, CFG_SPREAD, 16'd0, 16'd0, 16'd0, 3'd0, NO_PHRASE},
    '{ROW_TYPED, CFG_SPREAD, 16'd0, 16'd0, 16'd0, 3'd4,
      {TOKEN_LEFT, TOKEN_FRONT, TOKEN_RIGHT, TOKEN_CLOSE, 10'd0}},
    // Largest readings: the sum must not wrap and nothing is near.
    '{ROW_SWEEP, CFG_SPREAD, RMAX, RMAX, RMAX, 3'd0, NO_PHRASE},
    '{ROW_SWEEP, CFG_SPREAD, RMAX, RMAX, RMAX, 3'd0, NO_PHRASE},
    '{ROW_TYPED, CFG_SPREAD, RMAX, RMAX, RMAX, 3'd0, NO_PHRASE},
    // Left spread of 100 exceeds the limit of 50, so left reads as distance 0.
    '{ROW_SWEEP, CFG_SPREAD, 16'd100, 16'd500, 16'd500, 3'd0, NO_PHRASE},
    '{ROW_SWEEP, CFG_SPREAD, 16'd100, 16'd500, 16'd500, 3'd0, NO_PHRASE},
    '{ROW_TYPED, CFG_SPREAD, 16'd200, 16'd500, 16'd500, 3'd2,
      {TOKEN_LEFT, TOKEN_CLOSE, 20'd0}},
    // Panorama mode: the bucket edges at 50, 51 and 1050 cm.
    '{ROW_REG,   CFG_MODE,   16'd1, 16'd0, 16'd0, 3'd0, NO_PHRASE},
    '{ROW_SWEEP, CFG_SPREAD, 16'd50, 16'd51, 16'd1050, 3'd0, NO_PHRASE},
    '{ROW_SWEEP, CFG_SPREAD, 16'd50, 16'd51, 16'd1050, 3'd0, NO_PHRASE},
    '{ROW_TYPED, CFG_SPREAD, 16'd50, 16'd51, 16'd1050, 3'd6,
      {TOKEN_LEFT, TOKEN_CLOSE, TOKEN_FRONT, TOKEN_METRE1, TOKEN_RIGHT, TOKEN_TEN_M}},
    // Just past the far edge, and truncating averages around 150 cm.
    '{ROW_SWEEP, CFG_SPREAD, 16'd1051, 16'd150, 16'd151, 3'd0, NO_PHRASE},
    '{ROW_SWEEP, CFG_SPREAD, 16'd1052, 16'd150, 16'd151, 3'd0, NO_PHRASE},
    '{ROW_SWEEP, CFG_SPREAD, 16'd1051, 16'd151, 16'd152, 3'd0, NO_PHRASE},
    // Mode changes inside a group: the setting at the closing sweep decides.
    '{ROW_SWEEP, CFG_SPREAD, 16'd0, 16'd950, 16'd951, 3'd0, NO_PHRASE},
    '{ROW_SWEEP, CFG_SPREAD, 16'd100, 16'd950, 16'd951, 3'd0, NO_PHRASE},
    '{ROW_REG,   CFG_MODE,   16'd0, 16'd0, 16'd0, 3'd0, NO_PHRASE},
    '{ROW_SWEEP, CFG_SPREAD, 16'd40, 16'd950, 16'd951, 3'd0, NO_PHRASE},
    // Lowest limits: with near_limit at 0 even an error distance is not near.
    '{ROW_REG,   CFG_SPREAD, 16'd0, 16'd0, 16'd0, 3'd0, NO_PHRASE},
    '{ROW_REG,   CFG_NEAR,   16'd0, 16'd0, 16'd0, 3'd0, NO_PHRASE},
    '{ROW_SWEEP, CFG_SPREAD, 16'd0, 16'd5, RMAX, 3'd0, NO_PHRASE},
    '{ROW_SWEEP, CFG_SPREAD, 16'd0, 16'd5, RMAX, 3'd0, NO_PHRASE},
    '{ROW_TYPED, CFG_SPREAD, 16'd0, 16'd5, RMAX, 3'd0, NO_PHRASE},
    // Highest limits, plus a write to the unused index with all ones.
    '{ROW_REG,   CFG_SPREAD, RMAX, 16'd0, 16'd0, 3'd0, NO_PHRASE},
    '{ROW_REG,   CFG_NEAR,   RMAX, 16'd0, 16'd0, 3'd0, NO_PHRASE},
    '{ROW_REG,   CFG_UNUSED, RMAX, 16'd0, 16'd0, 3'd0, NO_PHRASE},
    '{ROW_SWEEP, CFG_SPREAD, 16'd0, RMAX, 16'd1, 3'd0, NO_PHRASE},
    '{ROW_SWEEP, CFG_SPREAD, RMAX, RMAX, 16'd1, 3'd0, NO_PHRASE},
    '{ROW_SWEEP, CFG_SPREAD, 16'd0, RMAX, 16'd1, 3'd0, NO_PHRASE},
    // Back to panorama with the full spread allowed.
    '{ROW_REG,   CFG_MODE,   16'd1, 16'd0, 16'd0, 3'd0, NO_PHRASE}
  };

  // The last plan row switches to panorama; this group closes the plan.
  localparam range_t LAST_GROUP [3][3] = '{
    '{RMAX, 16'd0, 16'd1}, '{16'd0, 16'd0, 16'd1}, '{RMAX, 16'd0, 16'd1}
  };

  logic     clk = 1'b0;
  logic     rst_n = 1'b0;
  logic     in_valid = 1'b0;
  logic     in_stall;
  range_t   in_left_range = '0;
  range_t   in_front_range = '0;
  range_t   in_right_range = '0;
  logic     out_valid;
  logic     out_stall = 1'b0;
  code_t    out_track_code;
  logic     out_last_token;
  logic     cfg_valid = 1'b0;
  logic     cfg_ready;
  cfg_idx_t cfg_index = CFG_SPREAD;
  range_t   cfg_data = '0;

  // Shadow registers and group accumulators of the in-bench phrase model.
  range_t spread_lim = SPREAD_RESET;
  range_t near_lim = NEAR_RESET;
  logic   panorama = 1'b0;
  sum_t   acc_sum [SENSORS];
  range_t acc_min [SENSORS];
  range_t acc_max [SENSORS];
  int     sweeps_in_group = 0;

  // Tokens still owed by the block, oldest first, and the phrase just built.
  token_t tokens_due [$];
  token_t phrase [$];

  int unsigned send_idle_pct = 28;
  int unsigned recv_stall_pct = 57;
  int errors = 0;
  int cycles = 0;
  int sweeps_sent = 0;
  int tokens_seen = 0;
  int phrases_seen = 0;
  int reg_writes = 0;

  sonar_proximity_phrase_builder #(
    .ROUNDS(ROUNDS)
  ) dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_left_range  (in_left_range),
    .in_front_range (in_front_range),
    .in_right_range (in_right_range),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_track_code (out_track_code),
    .out_last_token (out_last_token),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // The receiver stalls on a fresh coin every cycle, at the current rate.
  always @(posedge clk) begin
    out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
  end

  // Folds one accepted sweep into the group and, on the closing sweep of a
  // group, builds the phrase that the block should speak into phrase.
  task automatic fold_sweep(input range_t left, input range_t front, input range_t right);
    range_t reading [SENSORS];
    range_t group_dist [SENSORS];
    code_t  code;
    reading[0] = left;
    reading[1] = front;
    reading[2] = right;
    phrase.delete();
    for (int s = 0; s < SENSORS; s++) begin
      if (sweeps_in_group == 0) begin
        acc_sum[s] = sum_t'(reading[s]);
        acc_min[s] = reading[s];
        acc_max[s] = reading[s];
      end else begin
        acc_sum[s] = acc_sum[s] + sum_t'(reading[s]);
        if (reading[s] < acc_min[s]) acc_min[s] = reading[s];
        if (reading[s] > acc_max[s]) acc_max[s] = reading[s];
      end
    end
    sweeps_in_group++;
    if (sweeps_in_group < ROUNDS) return;
    sweeps_in_group = 0;

    // A group whose readings scatter too widely is treated as distance 0.
    for (int s = 0; s < SENSORS; s++) begin
      if (acc_max[s] - acc_min[s] > spread_lim) begin
        group_dist[s] = '0;
      end else begin
        group_dist[s] = range_t'(acc_sum[s] / sum_t'(ROUNDS));
      end
    end

    if (panorama) begin
      // Location then distance bucket for each sensor, left to right.
      for (int s = 0; s < SENSORS; s++) begin
        if (group_dist[s] <= BUCKET_CLOSE_CM) begin
          code = TOKEN_CLOSE;
        end else if (group_dist[s] > BUCKET_FAR_CM) begin
          code = TOKEN_FAR;
        end else begin
          code = TOKEN_METRE1 +
                 code_t'((group_dist[s] - BUCKET_CLOSE_CM - 16'd1) / METRE_CM);
        end
        phrase.push_back(token_t'{code: SIDE_TOKEN[s], last: 1'b0});
        phrase.push_back(token_t'{code: code, last: (s == SENSORS - 1)});
      end
    end else begin
      // Only the near sides are named, and a closing warning follows them.
      for (int s = 0; s < SENSORS; s++) begin
        if (group_dist[s] < near_lim) begin
          phrase.push_back(token_t'{code: SIDE_TOKEN[s], last: 1'b0});
        end
      end
      if (phrase.size() > 0) phrase.push_back(token_t'{code: TOKEN_CLOSE, last: 1'b1});
    end
  endtask

  // Offers one sweep after a random idle gap and holds it until accepted.
  // Typed rows queue the answer written in the plan; the model still folds
  // the sweep so that its group state stays in step.
  task automatic send_sweep(input range_t left, input range_t front, input range_t right,
                            input logic typed, input int n_typed, input phrase_t typed_codes);
    cfg_valid <= 1'b0;
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_left_range <= left;
    in_front_range <= front;
    in_right_range <= right;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    fold_sweep(left, front, right);
    sweeps_sent++;
    if (typed) begin
      for (int k = 0; k < n_typed; k++) begin
        tokens_due.push_back(token_t'{code: typed_codes[5 - k], last: (k == n_typed - 1)});
      end
    end else begin
      foreach (phrase[k]) tokens_due.push_back(phrase[k]);
    end
  endtask

  // Leaves cfg_valid high on return so that back-to-back writes need no gap;
  // the next sweep or idle wait lowers it.
  task automatic write_reg(input cfg_idx_t idx, input range_t data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    reg_writes++;
    case (idx)
      CFG_SPREAD: spread_lim = data;
      CFG_NEAR:   near_lim = data;
      CFG_MODE:   panorama = data[0];
      default: ;
    endcase
  endtask

  // Drains every owed token, then lets a sweep still inside the pipeline
  // settle so that a register write cannot overtake it.
  task automatic wait_quiet();
    in_valid <= 1'b0;
    cfg_valid <= 1'b0;
    while (tokens_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Every token taken by the bench is matched against the oldest one owed.
  always @(posedge clk) begin
    token_t want;
    if (rst_n && out_valid && !out_stall) begin
      tokens_seen++;
      if (out_last_token) phrases_seen++;
      if (tokens_due.size() == 0) begin
        errors++;
        $display("%0t: token %0d last %0b arrived with nothing expected",
                 $time, out_track_code, out_last_token);
      end else begin
        want = tokens_due.pop_front();
        if (out_track_code !== want.code) begin
          errors++;
          $display("%0t: track_code expected %0d, got %0d",
                   $time, want.code, out_track_code);
        end
        if (out_last_token !== want.last) begin
          errors++;
          $display("%0t: last_token expected %0b, got %0b",
                   $time, want.last, out_last_token);
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("Timed out after %0d cycles, %0d tokens still owed",
               cycles, tokens_due.size());
      $display("FAILURE");
      $finish;
    end
  end

  initial begin
    int     pick;
    int     x;
    int     plan_sweeps;
    int     grp_base [SENSORS];
    int     grp_jit [SENSORS];
    range_t val [SENSORS];
    range_t spread_val;
    range_t near_val;
    range_t mode_val;

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // Directed plan, under the first idle pattern.
    for (int i = 0; i < PLAN_ROWS; i++) begin
      if (PLAN[i].kind == ROW_REG) begin
        wait_quiet();
        write_reg(PLAN[i].idx, PLAN[i].a);
      end else begin
        send_sweep(PLAN[i].a, PLAN[i].b, PLAN[i].c, PLAN[i].kind == ROW_TYPED,
                   int'(PLAN[i].n_due), PLAN[i].due);
      end
    end
    for (int i = 0; i < 3; i++) begin
      send_sweep(LAST_GROUP[i][0], LAST_GROUP[i][1], LAST_GROUP[i][2], 1'b0, 0, NO_PHRASE);
    end
    plan_sweeps = sweeps_sent;

    // Random groups. Two phases per idle pattern, one per phrase mode, each
    // with fresh limits. Most sweeps sit near a per-group base with a small
    // jitter so that groups pass the spread check; some jitter widely and a
    // few readings are pure noise to trip it.
    for (int ph = 0; ph < PHASES; ph++) begin
      wait_quiet();
      send_idle_pct = (ph < 2) ? 28 : (ph < 4) ? 57 : 0;
      recv_stall_pct = (ph < 2) ? 57 : (ph < 4) ? 28 : 0;

      pick = $urandom_range(0, 9);
      spread_val = (pick < 6) ? range_t'($urandom_range(0, 150)) :
                   (pick < 8) ? range_t'($urandom) : (pick == 8) ? '0 : RMAX;
      pick = $urandom_range(0, 9);
      near_val = (pick < 6) ? range_t'($urandom_range(0, 1200)) :
                 (pick < 8) ? range_t'($urandom) : (pick == 8) ? '0 : RMAX;
      // Only bit 0 selects the mode; the upper bits are random filler.
      mode_val = range_t'($urandom);
      mode_val[0] = ph[0];
      write_reg(CFG_SPREAD, spread_val);
      write_reg(CFG_NEAR, near_val);
      write_reg(CFG_MODE, mode_val);
      if (ph == 3) write_reg(CFG_UNUSED, range_t'($urandom));

      for (int n = 0; n < PHASE_SWEEPS; n++) begin
        if (sweeps_in_group == 0) begin
          for (int s = 0; s < SENSORS; s++) begin
            pick = $urandom_range(0, 9);
            if (pick < 4) begin
              grp_base[s] = $urandom_range(0, 200);
            end else if (pick < 8) begin
              grp_base[s] = $urandom_range(0, 1200);
            end else if (pick == 8) begin
              grp_base[s] = $urandom_range(0, 65535);
            end else begin
              grp_base[s] = ($urandom_range(0, 1) == 1) ? 65535 : 0;
            end
            grp_jit[s] = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 400) :
                         $urandom_range(0, 40);
          end
        end
        for (int s = 0; s < SENSORS; s++) begin
          if ($urandom_range(0, 9) == 0) begin
            val[s] = range_t'($urandom);
          end else begin
            x = grp_base[s] + int'($urandom_range(0, grp_jit[s]));
            if (x > 65535) x = 65535;
            val[s] = range_t'(x);
          end
        end
        send_sweep(val[0], val[1], val[2], 1'b0, 0, NO_PHRASE);
      end
    end

    wait_quiet();
    $display("Covered %0d sweeps (%0d planned) and %0d tokens in %0d phrases,",
             sweeps_sent, plan_sweeps, tokens_seen, phrases_seen);
    $display("with %0d register writes across both modes and three idle patterns.",
             reg_writes);
    if (errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

// File: filelist.f
rtl/spp_pkg.sv
rtl/spp_accum.sv
rtl/spp_dist.sv
rtl/spp_phrase.sv
rtl/sonar_proximity_phrase_builder.sv
rtl/spp_checker.sv
dv/tb_sonar_proximity_phrase_builder.sv
